// ===== src/asfc_pkg.sv =====
package asfc_pkg;

	typedef enum logic [1:0] {
		SRC_I16 = 2'd0,
		SRC_I24 = 2'd1,
		SRC_I32 = 2'd2,
		SRC_F32 = 2'd3
	} src_type_t;

	typedef enum logic [1:0] {
		DST_S16 = 2'd0,
		DST_S32 = 2'd1,
		DST_F32 = 2'd2,
		DST_F64 = 2'd3
	} dst_fmt_t;

	typedef enum logic [0:0] {
		REG_SOURCE_TYPE = 1'b0,
		REG_DEST_FORMAT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] sample_in;
		logic        last_in;
	} in_item_t;

	typedef struct packed {
		logic [63:0] sample_out;
		logic        unsupported;
		logic        last_out;
	} out_item_t;

	// Conversion kind, decided once in the first stage.
	typedef enum logic [2:0] {
		K_BAD   = 3'd0,
		K_RAW   = 3'd1,  // pass a precomputed pattern
		K_I2F32 = 3'd2,
		K_I2F64 = 3'd3,
		K_F2F64 = 3'd4,
		K_F2S32 = 3'd5,
		K_F2S16 = 3'd6
	} kind_t;

endpackage

// ===== src/audio_sample_format_converter_top.sv =====
// Channel   | Signals                          | Handshake
// ----------+----------------------------------+--------------------------
// input     | start, busy, in_item             | taken when start && !busy
// result    | done, out_item                   | one-cycle strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_index, | write when valid && ready
//           | cfg_data                         |
//
// Three register stages: classify, normalize, round/pack. One item per
// cycle; an item taken on start passes the stage 1, 2 and 3 registers
// in order and is then strobed on done together with its result.
// busy is tied low: the receiver cannot stall, so nothing ever backs up.
// Reset clears only the stage valid bits and the two config registers.
module audio_sample_format_converter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  asfc_pkg::in_item_t   in_item,
	output logic                 done,
	output asfc_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [1:0]           cfg_data
);
	logic [1:0] src_q, dst_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 2'd0;
			dst_q <= 2'd0;
		end else if (cfg_valid) begin
			unique case (asfc_pkg::reg_idx_t'(cfg_index))
				asfc_pkg::REG_SOURCE_TYPE: src_q <= cfg_data;
				asfc_pkg::REG_DEST_FORMAT: dst_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1, sign_s1, last_s1;
	asfc_pkg::kind_t kind_s1;
	logic [31:0] mag_s1;
	logic [5:0]  sexp_s1;
	logic [63:0] raw_s1;

	asfc_front u_front (
		.clk, .arst_n, .v_in(start), .item(in_item), .src(src_q), .dst(dst_q),
		.v_s1, .kind_s1, .sign_s1, .mag_s1, .sexp_s1, .raw_s1, .last_s1
	);

	logic v_s2, sign_s2, zero_s2, last_s2;
	asfc_pkg::kind_t kind_s2;
	logic [31:0] nrm_s2;
	logic [4:0]  lz_s2;
	logic [63:0] raw_s2;
	logic [5:0]  sexp_s2;

	asfc_norm u_norm (
		.clk, .arst_n, .v_s1, .kind_s1, .sign_s1, .mag_s1, .sexp_s1, .raw_s1, .last_s1,
		.v_s2, .kind_s2, .sign_s2, .nrm_s2, .lz_s2, .zero_s2, .raw_s2, .sexp_s2, .last_s2
	);

	asfc_pack u_pack (
		.clk, .arst_n, .v_s2, .kind_s2, .sign_s2, .nrm_s2, .lz_s2, .zero_s2,
		.raw_s2, .sexp_s2, .last_s2, .v_s3(done), .res_s3(out_item)
	);
endmodule

// ===== src/asfc_front.sv =====
// Stage 1: classify and prepare magnitude or float fields.
module asfc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_in,
	input  asfc_pkg::in_item_t    item,
	input  logic [1:0]            src,
	input  logic [1:0]            dst,
	output logic                  v_s1,
	output asfc_pkg::kind_t       kind_s1,
	output logic                  sign_s1,
	output logic [31:0]           mag_s1,
	output logic [5:0]            sexp_s1,  // int->float: scale exponent 15/23/31
	output logic [63:0]           raw_s1,
	output logic                  last_s1
);
	logic [31:0] w;
	logic signed [31:0] s;
	asfc_pkg::kind_t k;
	logic [63:0] r;
	logic [5:0] se;

	always_comb begin
		w  = item.sample_in;
		s  = $signed(w);
		r  = '0;
		se = 6'd31;
		k  = asfc_pkg::K_BAD;
		unique case (asfc_pkg::src_type_t'(src))
			asfc_pkg::SRC_I16: begin
				s  = {{16{w[15]}}, w[15:0]};
				se = 6'd15;
				unique case (asfc_pkg::dst_fmt_t'(dst))
					asfc_pkg::DST_S16: begin k = asfc_pkg::K_RAW; r = {48'd0, w[15:0]}; end
					asfc_pkg::DST_F32: k = asfc_pkg::K_I2F32;
					asfc_pkg::DST_F64: k = asfc_pkg::K_I2F64;
					default:           k = asfc_pkg::K_BAD;
				endcase
			end
			asfc_pkg::SRC_I24, asfc_pkg::SRC_I32: begin
				se = (src == asfc_pkg::SRC_I24) ? 6'd23 : 6'd31;
				unique case (asfc_pkg::dst_fmt_t'(dst))
					asfc_pkg::DST_S32: begin
						k = asfc_pkg::K_RAW;
						r = (src == asfc_pkg::SRC_I24) ? {32'd0, w[23:0], 8'd0} : {32'd0, w};
					end
					asfc_pkg::DST_F32: k = asfc_pkg::K_I2F32;
					asfc_pkg::DST_F64: k = asfc_pkg::K_I2F64;
					default:           k = asfc_pkg::K_BAD;
				endcase
			end
			default: begin
				unique case (asfc_pkg::dst_fmt_t'(dst))
					asfc_pkg::DST_F32: begin k = asfc_pkg::K_RAW; r = {32'd0, w}; end
					asfc_pkg::DST_F64: k = asfc_pkg::K_F2F64;
					asfc_pkg::DST_S32: k = asfc_pkg::K_F2S32;
					default:           k = asfc_pkg::K_F2S16;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= v_in;
	end

	always_ff @(posedge clk) begin
		kind_s1 <= k;
		sign_s1 <= s[31];
		// float words pass untouched; integers become a magnitude
		if (src == asfc_pkg::SRC_F32) mag_s1 <= w;
		else if (s[31])               mag_s1 <= 32'd0 - s;
		else                          mag_s1 <= s;
		sexp_s1 <= se;
		raw_s1  <= r;
		last_s1 <= item.last_in;
	end
endmodule

// ===== src/asfc_norm.sv =====
// Stage 2: leading-one position and left-alignment for int->float; other kinds pass through.
module asfc_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_s1,
	input  asfc_pkg::kind_t  kind_s1,
	input  logic             sign_s1,
	input  logic [31:0]      mag_s1,
	input  logic [5:0]       sexp_s1,
	input  logic [63:0]      raw_s1,
	input  logic             last_s1,
	output logic             v_s2,
	output asfc_pkg::kind_t  kind_s2,
	output logic             sign_s2,
	output logic [31:0]      nrm_s2,   // int: left-aligned magnitude; float: raw word
	output logic [4:0]       lz_s2,
	output logic             zero_s2,
	output logic [63:0]      raw_s2,
	output logic [5:0]       sexp_s2,
	output logic             last_s2
);
	logic [4:0] lz;
	logic found;

	// Priority encode the leading one, scanning from the MSB.
	always_comb begin
		lz = 5'd0;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && mag_s1[i]) begin
				lz = 5'(31 - i);
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		sign_s2 <= sign_s1;
		lz_s2   <= lz;
		zero_s2 <= (mag_s1 == 32'd0);
		nrm_s2  <= (kind_s1 == asfc_pkg::K_I2F32 || kind_s1 == asfc_pkg::K_I2F64)
			? (mag_s1 << lz) : mag_s1;
		raw_s2  <= raw_s1;
		sexp_s2 <= sexp_s1;
		last_s2 <= last_s1;
	end
endmodule

// ===== src/asfc_pack.sv =====
// Stage 3: rounding, float products and packing of the result.
module asfc_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_s2,
	input  asfc_pkg::kind_t  kind_s2,
	input  logic             sign_s2,
	input  logic [31:0]      nrm_s2,
	input  logic [4:0]       lz_s2,
	input  logic             zero_s2,
	input  logic [63:0]      raw_s2,
	input  logic [5:0]       sexp_s2,
	input  logic             last_s2,
	output logic             v_s3,
	output asfc_pkg::out_item_t res_s3
);
	logic [63:0] r;
	logic [8:0]  e32;
	logic [10:0] e64;
	logic [23:0] m24;
	logic        rnd;
	logic [24:0] mr;
	// float path
	logic        fs;
	logic [7:0]  fe;
	logic [22:0] ff;
	logic        isnan, ge1;
	logic [23:0] fm;
	logic [47:0] prod;
	logic [31:0] ival;
	logic [8:0]  sh;
	logic [47:0] shv;
	logic [31:0] t;

	always_comb begin
		r   = '0;
		e32 = '0;
		e64 = '0;
		m24 = nrm_s2[31:8];
		rnd = nrm_s2[7] & (nrm_s2[8] | (|nrm_s2[6:0]));
		mr  = {1'b0, m24} + 25'(rnd);
		fs  = nrm_s2[31];
		fe  = nrm_s2[30:23];
		ff  = nrm_s2[22:0];
		isnan = (fe == 8'hFF) && (ff != 23'd0);
		ge1 = isnan || (fe >= 8'd127);
		fm  = {1'b1, ff};
		prod = '0;
		ival = '0;
		sh  = '0;
		shv = '0;
		t   = '0;
		unique case (kind_s2)
			asfc_pkg::K_RAW: r = raw_s2;
			asfc_pkg::K_I2F32: begin
				e32 = 9'd127 + 9'd31 - {4'd0, lz_s2} - {3'd0, sexp_s2};
				if (mr[24]) e32 = e32 + 9'd1;
				if (!zero_s2)
					r = {32'd0, sign_s2, e32[7:0],
						mr[24] ? mr[23:1] : mr[22:0]};
			end
			asfc_pkg::K_I2F64: begin
				e64 = 11'd1023 + 11'd31 - {6'd0, lz_s2} - {5'd0, sexp_s2};
				if (!zero_s2)
					r = {sign_s2, e64, nrm_s2[30:0], 21'd0};
			end
			asfc_pkg::K_F2F64: begin
				if (fe == 8'hFF)
					r = {fs, 11'h7FF, ff, 29'd0} | (isnan ? 64'h0008_0000_0000_0000 : 64'd0);
				else if (fe == 8'd0 && ff == 23'd0)
					r = {fs, 63'd0};
				else if (fe == 8'd0) begin
					// subnormal: normalize
					sh = '0;
					for (int i = 22; i >= 0; i--)
						if (sh == 9'd0 && ff[i]) sh = 9'(23 - i);
					shv = {25'd0, ff} << sh;
					r = {fs, 11'(11'd897 - 11'(sh)), shv[22:0], 29'd0};
				end else
					r = {fs, 11'(fe) + 11'd896, ff, 29'd0};
			end
			default: begin
				// F2S32 / F2S16: clamp, scale (F2S16 via a single-precision product), truncate
				if (kind_s2 == asfc_pkg::K_F2S32) begin
					if (ge1 && !(fs && !isnan)) ival = 32'h7FFF_FFFF;
					else if (ge1) ival = 32'h8000_0000;
					else if (fe < 8'd96) ival = 32'd0;
					else begin
						// x*2^31 rounded to 24 bits equals x*2^31 exactly when |x|<1
						sh = 9'd127 - 9'(fe);
						t  = {fm, 8'd0} >> sh[4:0];
						ival = fs ? (32'd0 - t) : t;
					end
					r = {32'd0, ival};
				end else if (kind_s2 == asfc_pkg::K_F2S16) begin
					if (ge1 && !(fs && !isnan)) ival = 32'd32767;
					else if (ge1) ival = 32'hFFFF_8001;
					else if (fe < 8'd112) ival = 32'd0;
					else begin
						prod = {24'd0, fm} * 48'd32767;
						// round product to 24 significant bits (nearest even)
						sh = (prod[38]) ? 9'd15 : 9'd14;
						shv = prod >> sh;
						if (prod[sh-1] && (shv[0] || ((prod & ((48'd1 << (sh-1)) - 48'd1)) != 0)))
							shv = shv + 48'd1;
						shv = shv << sh;
						t = 32'(shv >> (9'd23 + 9'd15 - (9'(fe) - 9'd112)));
						ival = fs ? (32'd0 - t) : t;
					end
					r = {48'd0, ival[15:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		res_s3.sample_out  <= (kind_s2 == asfc_pkg::K_BAD) ? 64'd0 : r;
		res_s3.unsupported <= (kind_s2 == asfc_pkg::K_BAD);
		res_s3.last_out    <= last_s2;
	end
endmodule
